// ===== sv/tapm_pkg.sv =====
// ----------------------------------------------------------------------------
// tapm_pkg
// Widths, configuration layout and stage-enable bundle for the three-axis
// PID motor mixer.
// ----------------------------------------------------------------------------
package tapm_pkg;

  localparam int ANG_W      = 18;  // widest angle field, signed Q9.8
  localparam int ERR_W      = 19;  // angle difference
  localparam int GAIN_W     = 16;  // unsigned Q4.12 gain
  localparam int PROD_W     = 36;  // gain times difference
  localparam int D_W        = 43;  // derivative product times 100
  localparam int INTEG_W    = 40;  // integral accumulator
  localparam int SUM_W      = 44;  // P + D + I
  localparam int FRAC_W     = 20;  // fraction bits of the products
  localparam int AXIS_W     = SUM_W - FRAC_W;
  localparam int MIX_W      = 27;  // throttle plus three axis terms
  localparam int PULSE_W    = 12;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  localparam int STAGES      = 7;  // lane stages plus mixer stages
  localparam int LANE_STAGES = 5;

  localparam logic [SUM_W-1:0] TRUNC_BIAS = {{(SUM_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P          = 3'd0,
    REG_GAIN_I          = 3'd1,
    REG_GAIN_D          = 3'd2,
    REG_INTEGRAL_WINDOW = 3'd3,
    REG_ARM_THRESHOLD   = 3'd4,
    REG_PULSE_MIN       = 3'd5,
    REG_PULSE_MAX       = 3'd6,
    REG_MIX_MODE        = 3'd7
  } tapm_reg_idx_t;

  typedef enum logic {
    MIX_PITCH_ONLY = 1'b0,
    MIX_FULL_X     = 1'b1
  } tapm_mix_mode_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [GAIN_W-1:0]  integral_window;
    logic [PULSE_W-1:0] arm_threshold;
    logic [PULSE_W-1:0] pulse_min;
    logic [PULSE_W-1:0] pulse_max;
    tapm_mix_mode_t     mix_mode;
  } tapm_cfg_t;

  // Load strobes, one per pipeline stage, high only when a valid request
  // moves into that stage.
  typedef struct packed {
    logic ld_diff;
    logic ld_mul;
    logic ld_acc;
    logic ld_sum;
    logic ld_axis;
    logic ld_mix;
    logic ld_out;
  } tapm_stage_en_t;

endpackage

// ===== sv/tapm_axis_lane.sv =====
// ----------------------------------------------------------------------------
// tapm_axis_lane
// One PID lane: difference, gain products, integral update, axis sum and
// truncation toward zero to whole microseconds.
// ----------------------------------------------------------------------------
module tapm_axis_lane (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  tapm_pkg::tapm_stage_en_t               en,
  input  tapm_pkg::tapm_cfg_t                    cfg,
  input  logic                                   primed,
  input  logic signed [tapm_pkg::ANG_W-1:0]      meas,
  input  logic signed [tapm_pkg::ANG_W-1:0]      target,
  output logic signed [tapm_pkg::AXIS_W-1:0]     axis_out
);
  import tapm_pkg::*;

  logic signed [ANG_W-1:0]   last_r;
  logic signed [ERR_W-1:0]   err_r, err_nxt;
  logic signed [ERR_W-1:0]   dlt_r, dlt_nxt;
  logic [ERR_W-1:0]          mag;
  logic                      win_r, win_nxt;
  logic signed [PROD_W-1:0]  p_r, p_nxt;
  logic signed [PROD_W-1:0]  dg_r, dg_nxt;
  logic signed [PROD_W-1:0]  ii_r, ii_nxt;
  logic signed [PROD_W-1:0]  p3_r;
  logic signed [D_W-1:0]     dx;
  logic signed [D_W-1:0]     d3_r, d3_nxt;
  logic signed [INTEG_W:0]   acc;
  logic signed [INTEG_W-1:0] integ_r, integ_nxt;
  logic signed [SUM_W-1:0]   sum_r, sum_nxt;
  logic [SUM_W-1:0]          biased;
  logic signed [AXIS_W-1:0]  axis_r, axis_nxt;

  always_comb begin
    err_nxt = {meas[ANG_W-1], meas} - {target[ANG_W-1], target};
    dlt_nxt = primed ? ERR_W'({meas[ANG_W-1], meas} - {last_r[ANG_W-1], last_r}) : '0;

    mag     = err_r[ERR_W-1] ? ERR_W'(-err_r) : ERR_W'(err_r);
    win_nxt = mag < {{(ERR_W-GAIN_W){1'b0}}, cfg.integral_window};
    p_nxt   = $signed({1'b0, cfg.gain_p}) * err_r;
    dg_nxt  = $signed({1'b0, cfg.gain_d}) * dlt_r;
    ii_nxt  = $signed({1'b0, cfg.gain_i}) * err_r;

    // Times 100 as 64 + 32 + 4.
    dx     = D_W'(dg_r);
    d3_nxt = (dx <<< 6) + (dx <<< 5) + (dx <<< 2);

    acc = {integ_r[INTEG_W-1], integ_r} + (INTEG_W+1)'(ii_r);
    if (acc[INTEG_W] != acc[INTEG_W-1]) begin
      integ_nxt = acc[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    end else begin
      integ_nxt = acc[INTEG_W-1:0];
    end

    sum_nxt = SUM_W'(p3_r) + SUM_W'(d3_r) + SUM_W'(integ_r);

    // Adding all-ones below the binary point makes the shift round toward zero.
    biased   = sum_r + (sum_r[SUM_W-1] ? TRUNC_BIAS : '0);
    axis_nxt = biased[SUM_W-1:FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= '0;
      integ_r <= '0;
    end else begin
      if (en.ld_diff) begin
        last_r <= meas;
      end
      if (en.ld_acc && win_r) begin
        integ_r <= integ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld_diff) begin
      err_r <= err_nxt;
      dlt_r <= dlt_nxt;
    end
    if (en.ld_mul) begin
      p_r   <= p_nxt;
      dg_r  <= dg_nxt;
      ii_r  <= ii_nxt;
      win_r <= win_nxt;
    end
    if (en.ld_acc) begin
      p3_r <= p_r;
      d3_r <= d3_nxt;
    end
    if (en.ld_sum) begin
      sum_r <= sum_nxt;
    end
    if (en.ld_axis) begin
      axis_r <= axis_nxt;
    end
  end

  assign axis_out = axis_r;

endmodule

// ===== sv/tapm_mixer.sv =====
// ----------------------------------------------------------------------------
// tapm_mixer
// Merges the axis outputs (pitch alone, or all three in full-X mode) onto four
// motors around the throttle, clamps to pulse limits, holds the output register.
// ----------------------------------------------------------------------------
module tapm_mixer (
  input  logic                                clk,
  input  tapm_pkg::tapm_stage_en_t            en,
  input  tapm_pkg::tapm_cfg_t                 cfg,
  input  logic signed [tapm_pkg::AXIS_W-1:0]  axis_p,
  input  logic signed [tapm_pkg::AXIS_W-1:0]  axis_r,
  input  logic signed [tapm_pkg::AXIS_W-1:0]  axis_y,
  input  logic [tapm_pkg::PULSE_W-1:0]        thr,
  input  logic                                armed,
  output logic [tapm_pkg::PULSE_W-1:0]        motor_front_a,
  output logic [tapm_pkg::PULSE_W-1:0]        motor_front_b,
  output logic [tapm_pkg::PULSE_W-1:0]        motor_rear_a,
  output logic [tapm_pkg::PULSE_W-1:0]        motor_rear_b,
  output logic                                armed_out
);
  import tapm_pkg::*;

  logic signed [MIX_W-1:0]   t, p, r, y, lo, hi;
  logic signed [MIX_W-1:0]   mix_r [4];
  logic signed [MIX_W-1:0]   mix_nxt [4];
  logic                      arm_r;
  logic [PULSE_W-1:0]        mot_r [4];
  logic [PULSE_W-1:0]        mot_nxt [4];
  logic                      armed_r;

  always_comb begin
    t = {{(MIX_W-PULSE_W){1'b0}}, thr};
    p = MIX_W'(axis_p);
    r = MIX_W'(axis_r);
    y = MIX_W'(axis_y);
    case (cfg.mix_mode)
      MIX_FULL_X: begin
        mix_nxt[0] = t + p + r + y;
        mix_nxt[1] = t + p - r - y;
        mix_nxt[2] = t - p - r + y;
        mix_nxt[3] = t - p + r - y;
      end
      default: begin
        mix_nxt[0] = t + p;
        mix_nxt[1] = t + p;
        mix_nxt[2] = t - p;
        mix_nxt[3] = t - p;
      end
    endcase
  end

  always_comb begin
    lo = {{(MIX_W-PULSE_W){1'b0}}, cfg.pulse_min};
    hi = {{(MIX_W-PULSE_W){1'b0}}, cfg.pulse_max};
    for (int k = 0; k < 4; k++) begin
      // The lower limit wins when the limits are inverted.
      if (!arm_r || mix_r[k] < lo) begin
        mot_nxt[k] = cfg.pulse_min;
      end else if (mix_r[k] > hi) begin
        mot_nxt[k] = cfg.pulse_max;
      end else begin
        mot_nxt[k] = mix_r[k][PULSE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.ld_mix) begin
      mix_r <= mix_nxt;
      arm_r <= armed;
    end
    if (en.ld_out) begin
      mot_r   <= mot_nxt;
      armed_r <= arm_r;
    end
  end

  assign motor_front_a = mot_r[0];
  assign motor_front_b = mot_r[1];
  assign motor_rear_a  = mot_r[2];
  assign motor_rear_b  = mot_r[3];
  assign armed_out     = armed_r;

endmodule

// ===== sv/three_axis_pid_motor_mixer.sv =====
// ----------------------------------------------------------------------------
// three_axis_pid_motor_mixer
// Attitude PID on pitch, roll and yaw with quadcopter motor mixing.
// ----------------------------------------------------------------------------
// Each accepted request is one sensor sample and yields exactly one motor
// result. Three PID lanes run side by side in a five-stage pipeline and a
// two-stage mixer follows; a new request can be taken every cycle while the
// output is not stalled. The integral of each axis is updated in a single
// stage, which is what lets consecutive samples follow one another without
// gaps. A stalled output halts the unbroken run of full stages before it, while
// stages upstream of an empty stage keep moving; while the output register is
// empty the block is always ready. Configuration registers are written through
// the cfg_ port and should only change while no sample is in flight.
// ----------------------------------------------------------------------------
module three_axis_pid_motor_mixer (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [16:0]                  in_meas_pitch,
  input  logic signed [16:0]                  in_meas_roll,
  input  logic signed [17:0]                  in_meas_yaw,
  input  logic signed [16:0]                  in_target_pitch,
  input  logic signed [16:0]                  in_target_roll,
  input  logic signed [17:0]                  in_target_yaw,
  input  logic [tapm_pkg::PULSE_W-1:0]        in_throttle_us,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tapm_pkg::PULSE_W-1:0]        out_motor_front_a,
  output logic [tapm_pkg::PULSE_W-1:0]        out_motor_front_b,
  output logic [tapm_pkg::PULSE_W-1:0]        out_motor_rear_a,
  output logic [tapm_pkg::PULSE_W-1:0]        out_motor_rear_b,
  output logic                                out_armed,
  input  logic                                cfg_wr_en,
  input  logic [tapm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tapm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import tapm_pkg::*;

  tapm_cfg_t          cfg_r;
  logic               primed_r;
  logic [STAGES:1]    v_r;
  logic [STAGES+1:1]  ld;
  logic [STAGES:1]    vin;
  logic [STAGES:1]    go;
  tapm_stage_en_t     en;

  logic [PULSE_W-1:0] thr_r [LANE_STAGES];
  logic               arm_r [LANE_STAGES];

  logic signed [AXIS_W-1:0] axis_p, axis_r, axis_y;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p          <= 16'd6144;
      cfg_r.gain_i          <= 16'd20;
      cfg_r.gain_d          <= 16'd1638;
      cfg_r.integral_window <= 16'd3840;
      cfg_r.arm_threshold   <= 12'd1200;
      cfg_r.pulse_min       <= 12'd1000;
      cfg_r.pulse_max       <= 12'd2000;
      cfg_r.mix_mode        <= MIX_PITCH_ONLY;
    end else if (cfg_wr_en) begin
      case (tapm_reg_idx_t'(cfg_index))
        REG_GAIN_P:          cfg_r.gain_p          <= cfg_wdata;
        REG_GAIN_I:          cfg_r.gain_i          <= cfg_wdata;
        REG_GAIN_D:          cfg_r.gain_d          <= cfg_wdata;
        REG_INTEGRAL_WINDOW: cfg_r.integral_window <= cfg_wdata;
        REG_ARM_THRESHOLD:   cfg_r.arm_threshold   <= cfg_wdata[PULSE_W-1:0];
        REG_PULSE_MIN:       cfg_r.pulse_min       <= cfg_wdata[PULSE_W-1:0];
        REG_PULSE_MAX:       cfg_r.pulse_max       <= cfg_wdata[PULSE_W-1:0];
        REG_MIX_MODE:        cfg_r.mix_mode        <= tapm_mix_mode_t'(cfg_wdata[0]);
        default: ;
      endcase
    end
  end

  // A stage can load when it is empty or its occupant moves on this cycle.
  always_comb begin
    ld[STAGES+1] = out_ready;
    for (int k = STAGES; k >= 1; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
    vin[1] = in_valid;
    for (int k = 2; k <= STAGES; k++) begin
      vin[k] = v_r[k-1];
    end
    go = ld[STAGES:1] & vin;
  end

  assign en.ld_diff = go[1];
  assign en.ld_mul  = go[2];
  assign en.ld_acc  = go[3];
  assign en.ld_sum  = go[4];
  assign en.ld_axis = go[5];
  assign en.ld_mix  = go[6];
  assign en.ld_out  = go[7];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r      <= '0;
      primed_r <= 1'b0;
    end else begin
      for (int k = 1; k <= STAGES; k++) begin
        if (ld[k]) begin
          v_r[k] <= vin[k];
        end
      end
      if (en.ld_diff) begin
        primed_r <= 1'b1;
      end
    end
  end

  // Throttle and arm flag travel alongside the lanes.
  always_ff @(posedge clk) begin
    if (go[1]) begin
      thr_r[0] <= in_throttle_us;
      arm_r[0] <= in_throttle_us > cfg_r.arm_threshold;
    end
    for (int k = 1; k < LANE_STAGES; k++) begin
      if (go[k+1]) begin
        thr_r[k] <= thr_r[k-1];
        arm_r[k] <= arm_r[k-1];
      end
    end
  end

  tapm_axis_lane u_lane_pitch (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .cfg      (cfg_r),
    .primed   (primed_r),
    .meas     (ANG_W'(in_meas_pitch)),
    .target   (ANG_W'(in_target_pitch)),
    .axis_out (axis_p)
  );

  tapm_axis_lane u_lane_roll (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .cfg      (cfg_r),
    .primed   (primed_r),
    .meas     (ANG_W'(in_meas_roll)),
    .target   (ANG_W'(in_target_roll)),
    .axis_out (axis_r)
  );

  tapm_axis_lane u_lane_yaw (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .cfg      (cfg_r),
    .primed   (primed_r),
    .meas     (in_meas_yaw),
    .target   (in_target_yaw),
    .axis_out (axis_y)
  );

  tapm_mixer u_mixer (
    .clk           (clk),
    .en            (en),
    .cfg           (cfg_r),
    .axis_p        (axis_p),
    .axis_r        (axis_r),
    .axis_y        (axis_y),
    .thr           (thr_r[LANE_STAGES-1]),
    .armed         (arm_r[LANE_STAGES-1]),
    .motor_front_a (out_motor_front_a),
    .motor_front_b (out_motor_front_b),
    .motor_rear_a  (out_motor_rear_a),
    .motor_rear_b  (out_motor_rear_b),
    .armed_out     (out_armed)
  );

  assign in_ready  = ld[1];
  assign out_valid = v_r[STAGES];

endmodule

// ===== sv/tapm_port_monitor.sv =====
// ----------------------------------------------------------------------------
// tapm_port_monitor
// Port-level checks for the three-axis PID motor mixer, bound to the top.
// ----------------------------------------------------------------------------
module tapm_port_monitor (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [tapm_pkg::PULSE_W-1:0]     out_motor_front_a,
  input logic [tapm_pkg::PULSE_W-1:0]     out_motor_front_b,
  input logic [tapm_pkg::PULSE_W-1:0]     out_motor_rear_a,
  input logic [tapm_pkg::PULSE_W-1:0]     out_motor_rear_b,
  input logic                             out_armed
);

  // A result held back by the consumer must not change.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_motor_front_a)
      && $stable(out_motor_front_b) && $stable(out_motor_rear_a)
      && $stable(out_motor_rear_b) && $stable(out_armed))
    else $error("result changed while stalled");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // With the output register empty nothing can back up to the input.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with output empty");

  // Disarmed results hold every motor at the same lower limit.
  a_disarmed_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_armed |-> out_motor_front_a == out_motor_front_b
      && out_motor_front_a == out_motor_rear_a && out_motor_front_a == out_motor_rear_b)
    else $error("disarmed motors differ");

endmodule

bind three_axis_pid_motor_mixer tapm_port_monitor u_port_monitor (.*);
